// File: rtl/core/differential_drive_command_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the differential drive command unit
// Shared concurrent-assertion wrappers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_COMMAND_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_COMMAND_UNIT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define DDCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ddcu assertion failed");

// consequent checked in the same cycle as the antecedent
`define DDCU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ddcu assertion failed");

`endif

// File: rtl/core/ddcu_pkg.sv
// ----------------------------------------------------------------------------
// ddcu_pkg
// Types, command codes and constants of the differential drive command unit.
// ----------------------------------------------------------------------------
package ddcu_pkg;

   localparam int SPEED_W      = 8;
   localparam int TRIM_W       = 9;
   localparam int REQ_SPEED_W  = 16;
   localparam int FUNC_W       = 4;
   localparam int SUM_W        = 11;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 32;

   localparam logic [SPEED_W-1:0] SPEED_MAX     = 8'd255;
   localparam logic [SPEED_W-1:0] SPEED_STEP    = 8'd20;
   localparam logic [SPEED_W-1:0] SPEED_DEFAULT = 8'd200;

   localparam logic [1:0]         TURN_MODE_RST    = 2'd0;
   localparam logic [SPEED_W-1:0] TURN_OFFSET_RST  = 8'd54;
   localparam logic [SPEED_W-1:0] FIXED_SPEED_RST  = 8'd140;
   localparam logic [TRIM_W-1:0]  TRIM_RST         = 9'd0;

   typedef enum logic [FUNC_W-1:0] {
      FN_STOP          = 4'd0,
      FN_FORWARD       = 4'd1,
      FN_REVERSE       = 4'd2,
      FN_SPIN_LEFT     = 4'd3,
      FN_SPIN_RIGHT    = 4'd4,
      FN_FWD_LEFT      = 4'd5,
      FN_FWD_RIGHT     = 4'd6,
      FN_REV_LEFT      = 4'd7,
      FN_REV_RIGHT     = 4'd8,
      FN_SPEED_UP      = 4'd9,
      FN_SPEED_DOWN    = 4'd10,
      FN_SPEED_RESET   = 4'd11,
      FN_SPEED_SET     = 4'd12
   } func_type;

   typedef enum logic [1:0] {
      ACT_STOP = 2'd0,
      ACT_FWD  = 2'd1,
      ACT_REV  = 2'd2,
      ACT_TURN = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_STRAIGHT = 2'd0,
      KIND_PLUS     = 2'd1,
      KIND_MINUS    = 2'd2,
      KIND_SPIN     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_PLUS  = 2'd0,
      MODE_MINUS = 2'd1,
      MODE_FIXED = 2'd2,
      MODE_BARE  = 2'd3
   } turn_mode_type;

   typedef enum logic [2:0] {
      REG_TURN_MODE   = 3'd0,
      REG_TURN_OFFSET = 3'd1,
      REG_FIXED_SPEED = 3'd2,
      REG_LEFT_TRIM   = 3'd3,
      REG_RIGHT_TRIM  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [1:0]                turn_mode;
      logic [SPEED_W-1:0]        turn_offset;
      logic [SPEED_W-1:0]        fixed_turn_speed;
      logic signed [TRIM_W-1:0]  left_trim;
      logic signed [TRIM_W-1:0]  right_trim;
   } cfg_type;

endpackage

// File: rtl/core/differential_drive_command_unit.sv
// ----------------------------------------------------------------------------
// differential_drive_command_unit
// Two-wheel drive command unit with held wheel directions and duties.
// ----------------------------------------------------------------------------
// One command is accepted per clock cycle while results are not stalled. A
// command lands in an input register, is decoded against the held speed and
// action in combinational logic, and moves into the result register, which
// holds the updated state. The held state updates at most once per cycle, on
// each advance. Results stall without loss when rsp_tready is low;
// req_tready drops only when both stages are full. Settings must be written
// through the APB port while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "differential_drive_command_unit_macros.svh"

module differential_drive_command_unit (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ddcu_pkg::REQ_DATA_W-1:0]   req_tdata,  // [3:0] func, [19:4] speed_value
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ddcu_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [0] left_reverse,
                                                         // [1] right_reverse,
                                                         // [9:2] left_duty,
                                                         // [17:10] right_duty,
                                                         // [25:18] speed_now
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ddcu_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ddcu_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ddcu_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   ddcu_pkg::cfg_type cfg;

   // input stage
   logic                                   s1_valid_ff, s1_valid_in;
   logic [ddcu_pkg::FUNC_W-1:0]            s1_func_ff;
   logic signed [ddcu_pkg::REQ_SPEED_W-1:0] s1_speed_ff;
   logic                                   req_take;
   logic                                   advance;

   // held state, doubles as the result register
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [ddcu_pkg::SPEED_W-1:0]           speed_ff, speed_in;
   ddcu_pkg::action_type                   action_ff, action_in;
   logic                                   left_dir_ff, left_dir_in;
   logic                                   right_dir_ff, right_dir_in;
   logic [ddcu_pkg::SPEED_W-1:0]           left_level_ff, left_level_in;
   logic [ddcu_pkg::SPEED_W-1:0]           right_level_ff, right_level_in;

   ddcu_pkg::kind_type                     left_kind, right_kind;
   logic [ddcu_pkg::SPEED_W-1:0]           left_duty, right_duty;
   logic [ddcu_pkg::SPEED_W:0]             speed_up_sum;

   ddcu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   assign advance    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff  <= req_tdata[3:0];
         s1_speed_ff <= $signed(req_tdata[19:4]);
      end
   end

   assign speed_up_sum = {1'b0, speed_ff} + {1'b0, ddcu_pkg::SPEED_STEP};

   // command decode; duties use the speed after this command
   always_comb begin
      speed_in      = speed_ff;
      action_in     = action_ff;
      left_dir_in   = left_dir_ff;
      right_dir_in  = right_dir_ff;
      left_kind     = ddcu_pkg::KIND_STRAIGHT;
      right_kind    = ddcu_pkg::KIND_STRAIGHT;
      left_level_in  = left_level_ff;
      right_level_in = right_level_ff;
      unique case (s1_func_ff)
         ddcu_pkg::FN_STOP: begin
            action_in      = ddcu_pkg::ACT_STOP;
            left_dir_in    = 1'b0;
            right_dir_in   = 1'b0;
            left_level_in  = '0;
            right_level_in = '0;
         end
         ddcu_pkg::FN_FORWARD: begin
            action_in      = ddcu_pkg::ACT_FWD;
            left_dir_in    = 1'b0;
            right_dir_in   = 1'b0;
            left_level_in  = left_duty;
            right_level_in = right_duty;
         end
         ddcu_pkg::FN_REVERSE: begin
            action_in      = ddcu_pkg::ACT_REV;
            left_dir_in    = 1'b1;
            right_dir_in   = 1'b1;
            left_level_in  = left_duty;
            right_level_in = right_duty;
         end
         ddcu_pkg::FN_SPIN_LEFT, ddcu_pkg::FN_SPIN_RIGHT: begin
            action_in      = ddcu_pkg::ACT_TURN;
            left_dir_in    = (s1_func_ff == ddcu_pkg::FN_SPIN_LEFT);
            right_dir_in   = (s1_func_ff == ddcu_pkg::FN_SPIN_RIGHT);
            left_kind      = ddcu_pkg::KIND_SPIN;
            right_kind     = ddcu_pkg::KIND_SPIN;
            left_level_in  = left_duty;
            right_level_in = right_duty;
         end
         ddcu_pkg::FN_FWD_LEFT, ddcu_pkg::FN_REV_LEFT: begin
            action_in      = ddcu_pkg::ACT_TURN;
            left_dir_in    = (s1_func_ff == ddcu_pkg::FN_REV_LEFT);
            right_dir_in   = (s1_func_ff == ddcu_pkg::FN_REV_LEFT);
            left_kind      = ddcu_pkg::KIND_MINUS;
            right_kind     = ddcu_pkg::KIND_PLUS;
            left_level_in  = left_duty;
            right_level_in = right_duty;
         end
         ddcu_pkg::FN_FWD_RIGHT, ddcu_pkg::FN_REV_RIGHT: begin
            action_in      = ddcu_pkg::ACT_TURN;
            left_dir_in    = (s1_func_ff == ddcu_pkg::FN_REV_RIGHT);
            right_dir_in   = (s1_func_ff == ddcu_pkg::FN_REV_RIGHT);
            left_kind      = ddcu_pkg::KIND_PLUS;
            right_kind     = ddcu_pkg::KIND_MINUS;
            left_level_in  = left_duty;
            right_level_in = right_duty;
         end
         ddcu_pkg::FN_SPEED_UP, ddcu_pkg::FN_SPEED_DOWN,
         ddcu_pkg::FN_SPEED_RESET, ddcu_pkg::FN_SPEED_SET: begin
            unique case (s1_func_ff)
               ddcu_pkg::FN_SPEED_UP:
                  speed_in = speed_up_sum[ddcu_pkg::SPEED_W] ? ddcu_pkg::SPEED_MAX
                                                             : speed_up_sum[7:0];
               ddcu_pkg::FN_SPEED_DOWN:
                  speed_in = (speed_ff < ddcu_pkg::SPEED_STEP) ? '0
                                                               : speed_ff - ddcu_pkg::SPEED_STEP;
               ddcu_pkg::FN_SPEED_RESET:
                  speed_in = ddcu_pkg::SPEED_DEFAULT;
               default: begin
                  if (s1_speed_ff[ddcu_pkg::REQ_SPEED_W-1]) begin
                     speed_in = '0;
                  end else if (|s1_speed_ff[14:8]) begin
                     speed_in = ddcu_pkg::SPEED_MAX;
                  end else begin
                     speed_in = s1_speed_ff[7:0];
                  end
               end
            endcase
            // duties follow the new speed only while driving straight
            if (action_ff == ddcu_pkg::ACT_FWD || action_ff == ddcu_pkg::ACT_REV) begin
               left_level_in  = left_duty;
               right_level_in = right_duty;
            end
         end
         default: ;
      endcase
   end

   ddcu_wheel u_left (
      .kind             (left_kind),
      .speed            (speed_in),
      .trim             (cfg.left_trim),
      .turn_mode        (cfg.turn_mode),
      .turn_offset      (cfg.turn_offset),
      .fixed_turn_speed (cfg.fixed_turn_speed),
      .duty             (left_duty)
   );

   ddcu_wheel u_right (
      .kind             (right_kind),
      .speed            (speed_in),
      .trim             (cfg.right_trim),
      .turn_mode        (cfg.turn_mode),
      .turn_offset      (cfg.turn_offset),
      .fixed_turn_speed (cfg.fixed_turn_speed),
      .duty             (right_duty)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff       <= ddcu_pkg::SPEED_DEFAULT;
         action_ff      <= ddcu_pkg::ACT_STOP;
         left_dir_ff    <= 1'b0;
         right_dir_ff   <= 1'b0;
         left_level_ff  <= '0;
         right_level_ff <= '0;
      end else if (advance) begin
         speed_ff       <= speed_in;
         action_ff      <= action_in;
         left_dir_ff    <= left_dir_in;
         right_dir_ff   <= right_dir_in;
         left_level_ff  <= left_level_in;
         right_level_ff <= right_level_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, speed_ff, right_level_ff, left_level_ff,
                        right_dir_ff, left_dir_ff};

   // a staged command is never dropped while the result side stalls
   `DDCU_ASSERT_NEXT(a_stage_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff)
   // stop always leaves both wheels at rest, forward
   `DDCU_ASSERT_NEXT(a_stop_zero, clock, reset,
      advance && s1_func_ff == ddcu_pkg::FN_STOP,
      left_level_ff == '0 && right_level_ff == '0 && !left_dir_ff && !right_dir_ff)
   // motion commands never touch the base speed
   `DDCU_ASSERT_NEXT(a_motion_keeps_speed, clock, reset,
      advance && s1_func_ff != ddcu_pkg::FN_SPEED_UP && s1_func_ff != ddcu_pkg::FN_SPEED_DOWN &&
      s1_func_ff != ddcu_pkg::FN_SPEED_RESET && s1_func_ff != ddcu_pkg::FN_SPEED_SET,
      $stable(speed_ff))
   // the state only moves when a result is produced
   `DDCU_ASSERT_NEXT(a_state_on_advance, clock, reset, !advance,
      $stable(speed_ff) && $stable(left_level_ff) && $stable(right_level_ff))
   // a speed-up while turning leaves the duties alone
   `DDCU_ASSERT_SAME(a_refresh_gate, clock, reset,
      s1_valid_ff && action_ff == ddcu_pkg::ACT_TURN && s1_func_ff == ddcu_pkg::FN_SPEED_UP,
      left_level_in == left_level_ff && right_level_in == right_level_ff)

endmodule

// File: rtl/core/ddcu_csr.sv
// ----------------------------------------------------------------------------
// ddcu_csr
// APB register file holding the turn and trim settings.
// ----------------------------------------------------------------------------
module ddcu_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ddcu_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ddcu_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ddcu_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output ddcu_pkg::cfg_type                 cfg
);

   ddcu_pkg::cfg_type cfg_ff;
   ddcu_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            ddcu_pkg::REG_TURN_MODE:   cfg_in.turn_mode        = pwdata[1:0];
            ddcu_pkg::REG_TURN_OFFSET: cfg_in.turn_offset      = pwdata[7:0];
            ddcu_pkg::REG_FIXED_SPEED: cfg_in.fixed_turn_speed = pwdata[7:0];
            ddcu_pkg::REG_LEFT_TRIM:   cfg_in.left_trim        = $signed(pwdata[8:0]);
            ddcu_pkg::REG_RIGHT_TRIM:  cfg_in.right_trim       = $signed(pwdata[8:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.turn_mode        <= ddcu_pkg::TURN_MODE_RST;
         cfg_ff.turn_offset      <= ddcu_pkg::TURN_OFFSET_RST;
         cfg_ff.fixed_turn_speed <= ddcu_pkg::FIXED_SPEED_RST;
         cfg_ff.left_trim        <= ddcu_pkg::TRIM_RST;
         cfg_ff.right_trim       <= ddcu_pkg::TRIM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         ddcu_pkg::REG_TURN_MODE:   prdata = {30'd0, cfg_ff.turn_mode};
         ddcu_pkg::REG_TURN_OFFSET: prdata = {24'd0, cfg_ff.turn_offset};
         ddcu_pkg::REG_FIXED_SPEED: prdata = {24'd0, cfg_ff.fixed_turn_speed};
         ddcu_pkg::REG_LEFT_TRIM:   prdata = {{23{cfg_ff.left_trim[8]}}, cfg_ff.left_trim};
         ddcu_pkg::REG_RIGHT_TRIM:  prdata = {{23{cfg_ff.right_trim[8]}}, cfg_ff.right_trim};
         default:                   prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/ddcu_wheel.sv
// ----------------------------------------------------------------------------
// ddcu_wheel
// Duty calculation for one wheel: speed, trim and turn offset, clamped to 8 bits.
// ----------------------------------------------------------------------------
module ddcu_wheel (
   input  ddcu_pkg::kind_type                  kind,
   input  logic [ddcu_pkg::SPEED_W-1:0]        speed,
   input  logic signed [ddcu_pkg::TRIM_W-1:0]  trim,
   input  logic [1:0]                          turn_mode,
   input  logic [ddcu_pkg::SPEED_W-1:0]        turn_offset,
   input  logic [ddcu_pkg::SPEED_W-1:0]        fixed_turn_speed,
   output logic [ddcu_pkg::SPEED_W-1:0]        duty
);

   logic signed [ddcu_pkg::SUM_W-1:0] speed_x;
   logic signed [ddcu_pkg::SUM_W-1:0] trim_x;
   logic signed [ddcu_pkg::SUM_W-1:0] off_x;
   logic signed [ddcu_pkg::SUM_W-1:0] fixed_x;
   logic signed [ddcu_pkg::SUM_W-1:0] sum;

   assign speed_x = $signed({3'b000, speed});
   assign trim_x  = $signed({{2{trim[ddcu_pkg::TRIM_W-1]}}, trim});
   assign off_x   = $signed({3'b000, turn_offset});
   assign fixed_x = $signed({3'b000, fixed_turn_speed});

   always_comb begin
      sum = speed_x;
      unique case (kind)
         ddcu_pkg::KIND_STRAIGHT: sum = speed_x + trim_x;
         ddcu_pkg::KIND_PLUS:     sum = speed_x + trim_x + off_x;
         ddcu_pkg::KIND_MINUS:    sum = speed_x + trim_x - off_x;
         ddcu_pkg::KIND_SPIN: begin
            unique case (turn_mode)
               ddcu_pkg::MODE_PLUS:  sum = speed_x + trim_x + off_x;
               ddcu_pkg::MODE_MINUS: sum = speed_x + trim_x - off_x;
               ddcu_pkg::MODE_FIXED: sum = fixed_x + trim_x;
               ddcu_pkg::MODE_BARE:  sum = speed_x;
               default:              sum = speed_x;
            endcase
         end
         default: sum = speed_x;
      endcase
   end

   // clamp to 0..255
   always_comb begin
      if (sum[ddcu_pkg::SUM_W-1]) begin
         duty = '0;
      end else if (|sum[ddcu_pkg::SUM_W-2:ddcu_pkg::SPEED_W]) begin
         duty = ddcu_pkg::SPEED_MAX;
      end else begin
         duty = sum[ddcu_pkg::SPEED_W-1:0];
      end
   end

endmodule
